// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge, held off during reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/mevq_pkg.sv =====
// types and constants of the mouse event filter queue
`timescale 1ns / 1ps

package mevq_pkg;

    // ring geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int MASK_W     = 7;
    localparam int BTN_W      = 4;
    localparam int CODE_W     = 4;
    localparam int PIXEL_W    = 12;
    localparam int POS_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // event mask groups
    localparam logic [MASK_W-1:0] MASK_MOVE   = 7'h01;
    localparam logic [MASK_W-1:0] MASK_LEFT   = 7'h06;
    localparam logic [MASK_W-1:0] MASK_RIGHT  = 7'h18;
    localparam logic [MASK_W-1:0] MASK_CENTRE = 7'h60;

    localparam logic [MASK_W-1:0] EVENT_MASK_RESET = 7'd31;
    localparam logic [CODE_W-1:0] CODE_MOVE        = 4'h8;
    localparam logic [CODE_W-1:0] CODE_BUTTONS     = 4'h7;

    typedef enum logic [0:0] {
        OP_REPORT = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EVENT_MASK   = 1'b0,
        REG_QUEUE_ENABLE = 1'b1
    } t_cfg_reg;

    // one queue entry, row in the top bits
    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  column;
        logic [CODE_W-1:0] code;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // ring status seen by the top level
    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic             can_pop;
    } t_ring_status;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/mevq_ram.sv =====
// generic single port write, single port read ram with registered read
`timescale 1ns / 1ps

module mevq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mevq_filter.sv =====
// report filter: test mask, compare with kept state, keep or drop
`timescale 1ns / 1ps

module mevq_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_report,
    input  logic [mevq_pkg::MASK_W-1:0]   i_event_mask,
    input  logic [mevq_pkg::BTN_W-1:0]    i_buttons,
    output logic                          o_keep,
    output logic [mevq_pkg::CODE_W-1:0]   o_code
);

    logic [mevq_pkg::CODE_W-1:0] r_last_state;
    logic [mevq_pkg::CODE_W-1:0] n_last_state;
    logic [mevq_pkg::CODE_W-1:0] test_mask;
    logic [mevq_pkg::CODE_W-1:0] masked;
    logic [mevq_pkg::CODE_W-1:0] last_buttons;
    logic                        move_en;

    assign move_en = |(i_event_mask & mevq_pkg::MASK_MOVE);

    // move, centre, right, left
    assign test_mask = {move_en,
                        |(i_event_mask & mevq_pkg::MASK_CENTRE),
                        |(i_event_mask & mevq_pkg::MASK_RIGHT),
                        |(i_event_mask & mevq_pkg::MASK_LEFT)};

    assign masked       = i_buttons & test_mask;
    assign last_buttons = r_last_state & mevq_pkg::CODE_BUTTONS;

    always_comb begin
        if (last_buttons == masked) begin
            // no button change: kept only as a move event
            o_keep       = move_en;
            n_last_state = move_en ? (last_buttons | mevq_pkg::CODE_MOVE) : last_buttons;
        end else begin
            o_keep       = 1'b1;
            n_last_state = masked;
        end
    end

    assign o_code = n_last_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_state <= '0;
        end else if (i_report) begin
            r_last_state <= n_last_state;
        end
    end

endmodule

// ===== hw/rtl/mevq_ring.sv =====
// overwriting ring of events: pointers, fill count and entry store
`timescale 1ns / 1ps

module mevq_ring (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_enable,
    input  logic                   i_push,
    input  mevq_pkg::t_entry       i_push_entry,
    input  logic                   i_read,
    output mevq_pkg::t_ring_status o_status,
    output mevq_pkg::t_entry       o_rd_entry
);

    logic [mevq_pkg::PTR_W-1:0] r_write_ptr;
    logic [mevq_pkg::PTR_W-1:0] r_read_ptr;
    logic [mevq_pkg::CNT_W-1:0] r_fill;
    logic                       do_push;
    logic                       do_pop;
    logic                       full;
    logic [mevq_pkg::ENTRY_W-1:0] rdata;

    assign full    = (r_fill == mevq_pkg::CNT_W'(mevq_pkg::QUEUE_DEPTH));
    assign do_push = i_push && i_enable;
    assign do_pop  = i_read && i_enable && (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_ptr <= '0;
            r_read_ptr  <= '0;
            r_fill      <= '0;
        end else if (do_push) begin
            r_write_ptr <= mevq_pkg::ring_next(r_write_ptr);
            if (full) begin
                // oldest entry overwritten
                r_read_ptr <= mevq_pkg::ring_next(r_read_ptr);
            end else begin
                r_fill <= r_fill + mevq_pkg::CNT_W'(1);
            end
        end else if (do_pop) begin
            r_read_ptr <= mevq_pkg::ring_next(r_read_ptr);
            r_fill     <= r_fill - mevq_pkg::CNT_W'(1);
        end
    end

    mevq_ram #(
        .WIDTH (mevq_pkg::ENTRY_W),
        .DEPTH (mevq_pkg::QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_write_ptr),
        .i_wdata (i_push_entry),
        .i_re    (do_pop),
        .i_raddr (r_read_ptr),
        .o_rdata (rdata)
    );

    assign o_rd_entry       = mevq_pkg::t_entry'(rdata);
    assign o_status.fill    = r_fill;
    assign o_status.can_pop = i_enable && (r_fill != '0);

endmodule

// ===== hw/rtl/mouse_event_filter_queue.sv =====
// top level of the mouse event filter queue
`timescale 1ns / 1ps

// Mouse event filter and queue. One item is taken per clock unless a read is
// held off. A device report (opcode 0) is filtered against the test mask
// built from event_mask (one bit each for left, right, centre and move) and,
// when kept and queue_enable is set, pushed as {row, column, code} with
// coordinates divided by 8 into a QUEUE_DEPTH-entry ring that overwrites its
// oldest entry when full. Reports produce no result and are never held off.
// A read request (opcode 1) yields exactly one result in the cycle after
// acceptance: the popped entry with got_event 1, or all zeros when the queue
// is empty or disabled. The entry store is a single ram with one write and
// one registered read port; a read request is held off only while the result
// register is full and not being taken. Configuration is a plain write port
// (index 0 event_mask, index 1 queue_enable) that the user must write only
// while idle (not enforced). Stored entries survive disabling the queue.

`include "assert_macros.svh"

module mouse_event_filter_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [mevq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mevq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,

    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [mevq_pkg::BTN_W-1:0]          i_raw_buttons,
    input  logic [mevq_pkg::PIXEL_W-1:0]        i_pixel_x,
    input  logic [mevq_pkg::PIXEL_W-1:0]        i_pixel_y,

    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_got_event,
    output logic [mevq_pkg::CODE_W-1:0]         o_event_code,
    output logic [mevq_pkg::POS_W-1:0]          o_column,
    output logic [mevq_pkg::POS_W-1:0]          o_row
);

    // configuration registers
    logic [mevq_pkg::MASK_W-1:0] r_event_mask;
    logic                        r_queue_enable;

    // result register; entry fields come straight from the ram read register
    logic                        r_out_valid;
    logic                        r_got_event;

    logic                        in_accept;
    logic                        is_read;
    logic                        report_acc;
    logic                        read_acc;
    logic                        keep;
    logic [mevq_pkg::CODE_W-1:0] kept_code;
    mevq_pkg::t_entry            push_entry;
    mevq_pkg::t_entry            rd_entry;
    mevq_pkg::t_ring_status      ring_status;

    assign is_read = (i_opcode == mevq_pkg::OP_READ);

    // reports always go through; a read needs the result slot to free up
    assign o_in_ready = !is_read || !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign report_acc = in_accept && !is_read;
    assign read_acc   = in_accept && is_read;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_mask   <= mevq_pkg::EVENT_MASK_RESET;
            r_queue_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mevq_pkg::REG_EVENT_MASK: begin
                    r_event_mask <= i_cfg_wdata[mevq_pkg::MASK_W-1:0];
                end
                mevq_pkg::REG_QUEUE_ENABLE: begin
                    r_queue_enable <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // filter holds the last kept button state
    mevq_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_report     (report_acc),
        .i_event_mask (r_event_mask),
        .i_buttons    (i_raw_buttons),
        .o_keep       (keep),
        .o_code       (kept_code)
    );

    // coordinates divided by 8
    assign push_entry.code   = kept_code;
    assign push_entry.column = i_pixel_x[mevq_pkg::PIXEL_W-1 -: mevq_pkg::POS_W];
    assign push_entry.row    = i_pixel_y[mevq_pkg::PIXEL_W-1 -: mevq_pkg::POS_W];

    mevq_ring u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (r_queue_enable),
        .i_push       (report_acc && keep),
        .i_push_entry (push_entry),
        .i_read       (read_acc),
        .o_status     (ring_status),
        .o_rd_entry   (rd_entry)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_got_event <= 1'b0;
        end else if (read_acc) begin
            r_out_valid <= 1'b1;
            r_got_event <= ring_status.can_pop;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // empty or disabled read gives all zero fields
    assign o_out_valid  = r_out_valid;
    assign o_got_event  = r_got_event;
    assign o_event_code = r_got_event ? rd_entry.code   : '0;
    assign o_column     = r_got_event ? rd_entry.column : '0;
    assign o_row        = r_got_event ? rd_entry.row    : '0;

    // checks
    `ASSERT_NEVER(a_fill_bound, ring_status.fill > mevq_pkg::CNT_W'(mevq_pkg::QUEUE_DEPTH), "fill count beyond queue depth")
    `ASSERT_PROP(a_pop_result, (read_acc && ring_status.can_pop) |=> (o_out_valid && o_got_event), "pop did not produce an event result")
    `ASSERT_PROP(a_disabled_hold, !r_queue_enable |=> $stable(ring_status.fill), "fill count moved while queue disabled")

endmodule
